>>> rtl/kmd_pkg.sv
package kmd_pkg;

	localparam int unsigned SCAN_W = 24;
	localparam int unsigned CODE_W = 7;
	localparam int unsigned IDX_W  = 5;

	typedef logic [SCAN_W-1:0] scan_t;
	typedef logic [CODE_W-1:0] code_t;
	typedef logic [IDX_W-1:0]  idx_t;

	typedef struct packed {
		scan_t diff;
		scan_t scan;
		logic  flag;
	} qentry_t;

	function automatic code_t key_code_of(idx_t idx);
		code_t code;
		case (idx)
			5'd0:    code = 7'h41;
			5'd1:    code = 7'h42;
			5'd2:    code = 7'h43;
			5'd3:    code = 7'h3A;
			5'd4:    code = 7'h3C;
			5'd5:    code = 7'h3B;
			5'd6:    code = 7'h31;
			5'd7:    code = 7'h34;
			5'd8:    code = 7'h37;
			5'd9:    code = 7'h2E;
			5'd10:   code = 7'h3E;
			5'd11:   code = 7'h00;
			5'd12:   code = 7'h32;
			5'd13:   code = 7'h35;
			5'd14:   code = 7'h38;
			5'd15:   code = 7'h30;
			5'd16:   code = 7'h3D;
			5'd17:   code = 7'h3F;
			5'd18:   code = 7'h33;
			5'd19:   code = 7'h36;
			5'd20:   code = 7'h39;
			5'd21:   code = 7'h40;
			default: code = 7'h00;
		endcase
		return code;
	endfunction

endpackage

>>> rtl/kmd_front.sv
module kmd_front #(
	parameter int unsigned NUM_KEYS = 24
) (
	input  logic            clk,
	input  logic            arst_n,
	input  kmd_pkg::scan_t  scan_bits,
	input  logic            scan_valid,
	output logic            scan_ready,
	output kmd_pkg::qentry_t push_data,
	output logic            push_valid,
	input  logic            push_ready
);
	import kmd_pkg::*;

	localparam scan_t KEY_MASK = (NUM_KEYS >= SCAN_W) ? {SCAN_W{1'b1}} :
		SCAN_W'((33'(1) << NUM_KEYS) - 33'(1));

	scan_t prev_q;
	scan_t accepted_q;
	logic  flag_q;

	scan_t scan_m;
	logic  stable;
	logic  differs;
	logic  take;

	assign scan_m     = scan_bits & KEY_MASK;
	assign stable     = (scan_m == prev_q);
	assign differs    = (scan_m != accepted_q);
	assign scan_ready = push_ready;
	assign push_valid = scan_valid;
	assign take       = scan_valid && push_ready;

	always_comb begin
		push_data.scan = scan_m;
		push_data.diff = '0;
		push_data.flag = flag_q;
		if (stable) begin
			if (differs) begin
				push_data.diff = scan_m ^ accepted_q;
				push_data.flag = 1'b1;
			end else begin
				push_data.flag = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q     <= '1;
			accepted_q <= '1;
			flag_q     <= 1'b0;
		end else if (take) begin
			prev_q <= scan_m;
			flag_q <= push_data.flag;
			if (stable && differs) begin
				accepted_q <= scan_m;
			end
		end
	end

endmodule

>>> rtl/kmd_queue.sv
module kmd_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  kmd_pkg::qentry_t push_data,
	input  logic             push_valid,
	output logic             push_ready,
	output kmd_pkg::qentry_t pop_data,
	output logic             pop_valid,
	input  logic             pop_ready
);
	import kmd_pkg::*;

	qentry_t    slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_data   = slot_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

>>> rtl/kmd_back.sv
module kmd_back (
	input  logic             clk,
	input  logic             arst_n,
	input  kmd_pkg::qentry_t pop_data,
	input  logic             pop_valid,
	output logic             pop_ready,
	output logic             has_event,
	output kmd_pkg::code_t   key_code,
	output logic             released,
	output logic             changed_flag,
	output logic             last,
	output logic             result_valid,
	input  logic             result_ready
);
	import kmd_pkg::*;

	logic  busy_q;
	logic  out_valid_q;
	scan_t rest_q;
	scan_t bits_q;
	idx_t  idx_q;
	logic  flag_q;

	logic  out_free;
	logic  pop;
	logic  status;
	logic  emit_event;
	logic  step;
	logic  final_bit;

	assign out_free     = !out_valid_q || result_ready;
	assign pop_ready    = !busy_q && out_free;
	assign pop          = pop_valid && pop_ready;
	assign status       = pop && (pop_data.diff == '0);
	assign final_bit    = (rest_q[SCAN_W-1:1] == '0);
	assign emit_event   = busy_q && rest_q[0] && out_free;
	assign step         = busy_q && (!rest_q[0] || out_free);
	assign result_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (status || emit_event) begin
				out_valid_q <= 1'b1;
			end else if (result_valid && result_ready) begin
				out_valid_q <= 1'b0;
			end
			if (pop && !status) begin
				busy_q <= 1'b1;
			end else if (emit_event && final_bit) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			rest_q <= pop_data.diff;
			bits_q <= pop_data.scan;
			flag_q <= pop_data.flag;
			idx_q  <= '0;
		end else if (step) begin
			rest_q <= rest_q >> 1;
			bits_q <= bits_q >> 1;
			idx_q  <= idx_t'(idx_q + idx_t'(1));
		end
		if (status) begin
			has_event    <= 1'b0;
			key_code     <= '0;
			released     <= 1'b0;
			changed_flag <= pop_data.flag;
			last         <= 1'b1;
		end else if (emit_event) begin
			has_event    <= 1'b1;
			key_code     <= key_code_of(idx_q);
			released     <= bits_q[0];
			changed_flag <= flag_q;
			last         <= final_bit;
		end
	end

endmodule

>>> rtl/key_matrix_debounce_event_gen.sv
// Debounces full key matrix scans and reports key changes. A scan counts as stable
// when it matches the scan before it; a stable scan that differs from the accepted
// key state yields one event per changed key in ascending key order, and any other
// scan yields a single status transfer. The front end takes a scan whenever its
// two-entry queue has room. The back end walks the changed-key mask one bit per
// cycle, pausing at a changed key while the result side stalls, and stops after
// the highest changed key; it takes no new scan until the walk is done.
module key_matrix_debounce_event_gen #(
	parameter int unsigned NUM_KEYS = 24
) (
	input  logic           clk,
	input  logic           arst_n,
	input  kmd_pkg::scan_t scan_bits,
	input  logic           scan_valid,
	output logic           scan_ready,
	output logic           has_event,
	output kmd_pkg::code_t key_code,
	output logic           released,
	output logic           changed_flag,
	output logic           last,
	output logic           result_valid,
	input  logic           result_ready
);
	import kmd_pkg::*;

	qentry_t push_data;
	logic    push_valid;
	logic    push_ready;
	qentry_t pop_data;
	logic    pop_valid;
	logic    pop_ready;

	kmd_front #(
		.NUM_KEYS(NUM_KEYS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.scan_bits (scan_bits),
		.scan_valid(scan_valid),
		.scan_ready(scan_ready),
		.push_data (push_data),
		.push_valid(push_valid),
		.push_ready(push_ready)
	);

	kmd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_data (push_data),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.pop_data  (pop_data),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready)
	);

	kmd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.pop_data    (pop_data),
		.pop_valid   (pop_valid),
		.pop_ready   (pop_ready),
		.has_event   (has_event),
		.key_code    (key_code),
		.released    (released),
		.changed_flag(changed_flag),
		.last        (last),
		.result_valid(result_valid),
		.result_ready(result_ready)
	);

endmodule

>>> tb/key_matrix_debounce_event_gen_tb.sv
module key_matrix_debounce_event_gen_tb;

	import kmd_pkg::*;

	localparam int unsigned NKEYS       = 24;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned RAND_ITEMS  = 300;
	localparam int unsigned HOLD_CYCLES = 400;
	localparam int unsigned DRAIN       = 60;
	localparam int unsigned NDIR        = 22;

	localparam code_t KEY_MAP [0:23] = '{
		7'h41, 7'h42, 7'h43, 7'h3A, 7'h3C, 7'h3B,
		7'h31, 7'h34, 7'h37, 7'h2E, 7'h3E, 7'h00,
		7'h32, 7'h35, 7'h38, 7'h30, 7'h3D, 7'h3F,
		7'h33, 7'h36, 7'h39, 7'h40, 7'h00, 7'h00
	};

	typedef struct packed {
		logic  has_event;
		code_t key_code;
		logic  released;
		logic  changed_flag;
		logic  last;
	} key_result_t;

	typedef struct {
		scan_t scan;
		bit    typed;
		bit    exp_flag;
	} dir_row_t;

	logic  clk;
	logic  arst_n;
	scan_t scan_bits;
	logic  scan_valid;
	logic  scan_ready;
	logic  has_event;
	code_t key_code;
	logic  released;
	logic  changed_flag;
	logic  last;
	logic  result_valid;
	logic  result_ready;

	scan_t       prev_scan;
	scan_t       accepted_keys;
	logic        change_seen;
	key_result_t scan_results [$];
	key_result_t pending_results [$];
	dir_row_t    dir_table [NDIR];

	int unsigned mismatches;
	int unsigned cycles;
	int unsigned scans_sent;
	bit          idle_on;
	bit          hold_req;
	int unsigned hold_left;

	key_matrix_debounce_event_gen #(
		.NUM_KEYS(NKEYS)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.scan_bits   (scan_bits),
		.scan_valid  (scan_valid),
		.scan_ready  (scan_ready),
		.has_event   (has_event),
		.key_code    (key_code),
		.released    (released),
		.changed_flag(changed_flag),
		.last        (last),
		.result_valid(result_valid),
		.result_ready(result_ready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void debounce_step(input scan_t s);
		scan_t diff;
		diff = '0;
		scan_results.delete();
		if (s == prev_scan) begin
			if (s != accepted_keys) begin
				diff          = s ^ accepted_keys;
				accepted_keys = s;
				change_seen   = 1'b1;
			end else begin
				change_seen = 1'b0;
			end
		end
		prev_scan = s;
		for (int i = 0; i < NKEYS; i++) begin
			if (diff[i])
				scan_results.push_back('{1'b1, KEY_MAP[i], s[i], change_seen, 1'b0});
		end
		if (scan_results.size() == 0)
			scan_results.push_back('{1'b0, 7'h00, 1'b0, change_seen, 1'b1});
		else
			scan_results[$].last = 1'b1;
	endfunction

	task automatic send_scan(input scan_t s, input bit typed, input bit exp_flag);
		while (idle_on && $urandom_range(0, 99) < 21) begin
			scan_valid <= 1'b0;
			@(posedge clk);
		end
		scan_bits  <= s;
		scan_valid <= 1'b1;
		@(posedge clk);
		while (!scan_ready)
			@(posedge clk);
		debounce_step(s);
		if (typed)
			pending_results.push_back('{1'b0, 7'h00, 1'b0, exp_flag, 1'b1});
		else
			foreach (scan_results[k])
				pending_results.push_back(scan_results[k]);
		scans_sent++;
	endtask

	task automatic report_fail(input string what, input key_result_t want, input key_result_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("%s: exp ev=%0d code=%h rel=%0d flag=%0d last=%0d, got ev=%0d code=%h rel=%0d flag=%0d last=%0d",
				what, want.has_event, want.key_code, want.released, want.changed_flag, want.last,
				got.has_event, got.key_code, got.released, got.changed_flag, got.last);
	endtask

	always @(posedge clk) begin : result_check
		key_result_t got;
		key_result_t want;
		if (arst_n && result_valid && result_ready) begin
			got = '{has_event, key_code, released, changed_flag, last};
			if (pending_results.size() == 0) begin
				report_fail("unexpected result", '0, got);
			end else begin
				want = pending_results.pop_front();
				if (got.has_event !== want.has_event || got.key_code !== want.key_code ||
				    got.released !== want.released || got.changed_flag !== want.changed_flag ||
				    got.last !== want.last)
					report_fail("result mismatch", want, got);
			end
		end
	end

	initial begin
		result_ready = 1'b0;
		hold_left    = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ready <= 1'b0;
			end else begin
				result_ready <= !(idle_on && $urandom_range(0, 99) < 21);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin : stimulus
		scan_t target;
		scan_t flips;
		int unsigned pick;
		int unsigned nflip;

		arst_n        = 1'b0;
		scan_bits     = '0;
		scan_valid    = 1'b0;
		mismatches    = 0;
		cycles        = 0;
		scans_sent    = 0;
		idle_on       = 1'b1;
		hold_req      = 1'b0;
		prev_scan     = '1;
		accepted_keys = '1;
		change_seen   = 1'b0;

		dir_table = '{
			'{24'hFFFFFF, 1'b1, 1'b0},
			'{24'h000000, 1'b1, 1'b0},
			'{24'h000000, 1'b0, 1'b0},
			'{24'h000000, 1'b1, 1'b0},
			'{24'hFFFFFF, 1'b1, 1'b0},
			'{24'hFFFFFF, 1'b0, 1'b0},
			'{24'hFFFFFE, 1'b0, 1'b0},
			'{24'hFFFFFE, 1'b0, 1'b0},
			'{24'h7FFFFF, 1'b0, 1'b0},
			'{24'h7FFFFF, 1'b0, 1'b0},
			'{24'h7FFFFF, 1'b1, 1'b0},
			'{24'hFFF7FF, 1'b0, 1'b0},
			'{24'hFFF7FF, 1'b0, 1'b0},
			'{24'hAAAAAA, 1'b0, 1'b0},
			'{24'h555555, 1'b0, 1'b0},
			'{24'h555555, 1'b0, 1'b0},
			'{24'hAAAAAA, 1'b0, 1'b0},
			'{24'hAAAAAA, 1'b0, 1'b0},
			'{24'h3FFFFF, 1'b0, 1'b0},
			'{24'h3FFFFF, 1'b0, 1'b0},
			'{24'hFFFFFF, 1'b0, 1'b0},
			'{24'hFFFFFF, 1'b0, 1'b0}
		};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_table[r])
			send_scan(dir_table[r].scan, dir_table[r].typed, dir_table[r].exp_flag);

		// Stall the result side while whole-matrix changes keep arriving.
		hold_req = 1'b1;
		repeat (3) begin
			send_scan(24'h000000, 1'b0, 1'b0);
			send_scan(24'h000000, 1'b0, 1'b0);
			send_scan(24'hFFFFFF, 1'b0, 1'b0);
			send_scan(24'hFFFFFF, 1'b0, 1'b0);
		end

		while (scans_sent < NDIR + RAND_ITEMS) begin
			idle_on = !(scans_sent >= 150 && scans_sent < 230);
			pick    = $urandom_range(0, 99);
			if (pick < 10) begin
				flips = scan_t'($urandom());
			end else begin
				flips = '0;
				nflip = $urandom_range(1, 3);
				repeat (nflip)
					flips[$urandom_range(0, NKEYS - 1)] = 1'b1;
			end
			target = accepted_keys ^ flips;
			if (pick < 65) begin
				send_scan(target, 1'b0, 1'b0);
				send_scan(target, 1'b0, 1'b0);
				if ($urandom_range(0, 3) == 0)
					send_scan(target, 1'b0, 1'b0);
			end else if (pick < 82) begin
				send_scan(target, 1'b0, 1'b0);
				send_scan(target ^ scan_t'($urandom()), 1'b0, 1'b0);
				send_scan(target, 1'b0, 1'b0);
				send_scan(target, 1'b0, 1'b0);
			end else begin
				send_scan(scan_t'($urandom()), 1'b0, 1'b0);
			end
		end

		scan_valid <= 1'b0;
		idle_on = 1'b1;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (pending_results.size() != 0)
			report_fail("missing result", pending_results[0], '0);

		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

>>> sim.f
rtl/kmd_pkg.sv
rtl/kmd_front.sv
rtl/kmd_queue.sv
rtl/kmd_back.sv
rtl/key_matrix_debounce_event_gen.sv
tb/key_matrix_debounce_event_gen_tb.sv
